// ----- sv/qeps_pkg.sv -----
`default_nettype none
// ============================================================================
// qeps_pkg: shared types, constants and table builders
// Register indexes, stage widths and the elaboration-time functions that
// build the exponent and quarter-wave sine tables.
// ============================================================================
package qeps_pkg;

    localparam int CHANNELS = 4;

    // Field widths.
    localparam int CV_W       = 17;
    localparam int KNOB_W     = 15;
    localparam int BASE_W     = 28;
    localparam int WAVE_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // Exponent path widths: Q30 mantissa in [1, 2), octave code 0..8.
    localparam int MANT_W     = 31;
    localparam int CODE_W     = 4;
    localparam int PROD_W     = BASE_W + MANT_W;
    localparam int SHIFT_W    = 6;
    localparam logic [SHIFT_W-1:0] SHIFT_TOP = 6'd34;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_C    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KNOB_D    = 3'd4;

    localparam logic [BASE_W-1:0] BASE_STEP_RESET = 28'd39370534;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

    // Mantissa and octave code handed from the pitch stage to the multiply.
    typedef struct packed {
        logic [MANT_W-1:0] mant;
        logic [CODE_W-1:0] code;
    } exp_word_t;

    // Integer square root, bit-pair method.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 2^(e / 2^eab) in Q30, as a rounded product of repeated square roots.
    function automatic logic [63:0] exp_entry(input int e, input int eab);
        logic [63:0] root;
        logic [63:0] acc;
        logic [63:0] ev;
        root = 64'd1 << 31;
        acc  = 64'd1 << 30;
        ev   = 64'(e);
        for (int j = 1; j <= 12; j++) begin
            if (j <= eab) begin
                root = isqrt64(root << 30);
                if (((ev >> (eab - j)) & 64'd1) != 64'd0) begin
                    acc = (acc * root + (64'd1 << 29)) >> 30;
                end
            end
        end
        return acc;
    endfunction

    // Rounded 32767 * sin(k * (pi/2) / 2^(sab-2)), 0 <= k <= 2^(sab-2).
    function automatic logic [63:0] quarter_sine(input int k, input int sab);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALF_PI_Q30 * 64'(k)) >> (sab - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    endfunction

endpackage
`default_nettype wire

// ----- sv/qeps_channels.sv -----
`default_nettype none
// ============================================================================
// qeps channel interfaces
// Valid/ready channels for the pitch voltages, the wave samples and the
// register write port.
// ============================================================================
interface qeps_cv_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qeps_pkg::CV_W-1:0]     cv_pitch_a;
    logic signed [qeps_pkg::CV_W-1:0]     cv_pitch_b;
    logic signed [qeps_pkg::CV_W-1:0]     cv_pitch_c;
    logic signed [qeps_pkg::CV_W-1:0]     cv_pitch_d;

    modport source (output valid, cv_pitch_a, cv_pitch_b, cv_pitch_c, cv_pitch_d,
                    input ready);
    modport sink   (input valid, cv_pitch_a, cv_pitch_b, cv_pitch_c, cv_pitch_d,
                    output ready);
endinterface

interface qeps_wave_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qeps_pkg::WAVE_W-1:0]   wave_a;
    logic signed [qeps_pkg::WAVE_W-1:0]   wave_b;
    logic signed [qeps_pkg::WAVE_W-1:0]   wave_c;
    logic signed [qeps_pkg::WAVE_W-1:0]   wave_d;

    modport source (output valid, wave_a, wave_b, wave_c, wave_d, input ready);
    modport sink   (input valid, wave_a, wave_b, wave_c, wave_d, output ready);
endinterface

interface qeps_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [qeps_pkg::CFG_IDX_W-1:0]       index;
    logic [qeps_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/qeps_pitch_exp.sv -----
`default_nettype none
// ============================================================================
// qeps_pitch_exp: pitch sum, clamp and exponent table
// Adds knob and CV, clamps to plus or minus 4 V and returns the Q30
// mantissa of 2^frac together with the octave code.
// ============================================================================
module qeps_pitch_exp #(
    parameter int EXP_ADDR_BITS = 8
) (
    input  wire logic signed [qeps_pkg::KNOB_W-1:0] knob,
    input  wire logic signed [qeps_pkg::CV_W-1:0]   cv,
    output qeps_pkg::exp_word_t                      word
);

    localparam int EXP_DEPTH = 1 << EXP_ADDR_BITS;

    logic [qeps_pkg::MANT_W-1:0] exp_rom [EXP_DEPTH];

    for (genvar i = 0; i < EXP_DEPTH; i++) begin : g_exp_rom
        localparam logic [63:0] ENTRY = qeps_pkg::exp_entry(i, EXP_ADDR_BITS);
        assign exp_rom[i] = ENTRY[qeps_pkg::MANT_W-1:0];
    end

    logic signed [17:0] sum;
    logic signed [17:0] clamped;
    logic        [17:0] offset_sum;
    logic        [15:0] u;
    logic [EXP_ADDR_BITS-1:0] e;

    always_comb
    begin
        sum = 18'(knob) + 18'(cv);
        if (sum > 18'sd16384) begin
            clamped = 18'sd16384;
        end else if (sum < -18'sd16384) begin
            clamped = -18'sd16384;
        end else begin
            clamped = sum;
        end
        // Shift the pitch up by 4 V so the octave is a plain bit field.
        offset_sum = 18'(clamped + 18'sd16384);
        u          = offset_sum[15:0];
        e          = u[11 -: EXP_ADDR_BITS];
        word.mant  = exp_rom[e];
        word.code  = u[15:12];
    end

endmodule
`default_nettype wire

// ----- sv/qeps_sine_lookup.sv -----
`default_nettype none
// ============================================================================
// qeps_sine_lookup: quarter-wave sine table
// Folds the phase address into the first quadrant, reads the magnitude and
// restores the sign.
// ============================================================================
module qeps_sine_lookup #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic [SINE_ADDR_BITS-1:0]           addr,
    output logic signed [qeps_pkg::WAVE_W-1:0]        sample
);

    localparam int QSIZE = 1 << (SINE_ADDR_BITS - 2);

    logic [qeps_pkg::WAVE_W-1:0] quarter_rom [QSIZE+1];

    for (genvar i = 0; i <= QSIZE; i++) begin : g_sine_rom
        localparam logic [63:0] ENTRY = qeps_pkg::quarter_sine(i, SINE_ADDR_BITS);
        assign quarter_rom[i] = ENTRY[qeps_pkg::WAVE_W-1:0];
    end

    logic [1:0]                  quad;
    logic [SINE_ADDR_BITS-3:0]   r;
    logic [SINE_ADDR_BITS-2:0]   k;
    logic [qeps_pkg::WAVE_W-1:0] mag;

    always_comb
    begin
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        r    = addr[SINE_ADDR_BITS-3:0];
        // Odd quadrants run the table backwards; k reaches QSIZE at the peak.
        if (quad[0]) begin
            k = (SINE_ADDR_BITS-1)'(QSIZE) - {1'b0, r};
        end else begin
            k = {1'b0, r};
        end
        mag = quarter_rom[k];
        if (quad[1]) begin
            sample = -$signed(mag);
        end else begin
            sample = $signed(mag);
        end
    end

endmodule
`default_nettype wire

// ----- sv/quad_exp_pitch_sine_oscillator_core.sv -----
`default_nettype none
// ============================================================================
// quad_exp_pitch_sine_oscillator_core: four-channel 1 V/octave sine NCO
// Each accepted pitch transfer advances four phase accumulators and yields
// one transfer of four sine samples. The block takes one transfer per clock
// cycle while the wave side does not stall; each result passes through an
// input register, a pitch/exponent stage, a multiply stage and the
// accumulate/sine stage that feeds the output register. The phase
// accumulators close their loop through a single register, which sets the
// one transfer per cycle rate. A stall on the wave side holds every stage in
// place; ready on the pitch side stays high while any stage ahead has room.
// Per channel the knob offset and the CV are summed in Q4.12 volts, clamped
// to plus or minus 4 V, turned into base_step * 2^pitch through an exponent
// table and a shift, and added to a wrapping PHASE_BITS accumulator whose top
// SINE_ADDR_BITS address a quarter-wave sine table (32767 is +5 V).
// Register writes are taken in any cycle and must only come while idle.
// ============================================================================
module quad_exp_pitch_sine_oscillator_core #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int EXP_ADDR_BITS  = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    qeps_cv_if.sink        cv,
    qeps_wave_if.source    wave,
    qeps_cfg_if.sink       cfg
);

    localparam int CH = qeps_pkg::CHANNELS;

    // ------------------------------------------------------------------
    // Configuration registers. The write port never stalls; indexes past
    // the last knob are dropped.
    // ------------------------------------------------------------------
    logic [qeps_pkg::BASE_W-1:0]        base_step_reg;
    logic signed [qeps_pkg::KNOB_W-1:0] knob_reg [CH];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_step_reg <= qeps_pkg::BASE_STEP_RESET;
            for (int c = 0; c < CH; c++) begin
                knob_reg[c] <= '0;
            end
        end else if (cfg.valid) begin
            case (cfg.index)
                qeps_pkg::REG_BASE_STEP: base_step_reg <= cfg.data[qeps_pkg::BASE_W-1:0];
                qeps_pkg::REG_KNOB_A:    knob_reg[0]   <= cfg.data[qeps_pkg::KNOB_W-1:0];
                qeps_pkg::REG_KNOB_B:    knob_reg[1]   <= cfg.data[qeps_pkg::KNOB_W-1:0];
                qeps_pkg::REG_KNOB_C:    knob_reg[2]   <= cfg.data[qeps_pkg::KNOB_W-1:0];
                qeps_pkg::REG_KNOB_D:    knob_reg[3]   <= cfg.data[qeps_pkg::KNOB_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage flow control. A stage may load when it is empty or when the
    // stage after it moves on in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s1_free;
    logic s2_free;
    logic s3_free;
    logic s4_free;

    assign s4_free  = !s4_valid_reg || wave.ready;
    assign s3_free  = !s3_valid_reg || s4_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign cv.ready = s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s1_free) begin
                s1_valid_reg <= cv.valid;
            end
            if (s2_free) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register.
    // ------------------------------------------------------------------
    logic signed [qeps_pkg::CV_W-1:0] cv_in [CH];
    logic signed [qeps_pkg::CV_W-1:0] cv_reg [CH];

    assign cv_in[0] = cv.cv_pitch_a;
    assign cv_in[1] = cv.cv_pitch_b;
    assign cv_in[2] = cv.cv_pitch_c;
    assign cv_in[3] = cv.cv_pitch_d;

    always_ff @(posedge clk)
    begin
        if (s1_free && cv.valid) begin
            cv_reg <= cv_in;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel datapath: exponent stage, multiply stage, and the phase
    // accumulator with the sine lookup into the output register.
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]                phase_acc_reg [CH];
    logic [PHASE_BITS-1:0]                phase_next    [CH];
    logic signed [qeps_pkg::WAVE_W-1:0]   sample        [CH];
    logic signed [qeps_pkg::WAVE_W-1:0]   wave_reg      [CH];

    for (genvar c = 0; c < CH; c++) begin : g_ch
        qeps_pkg::exp_word_t          exp_word;
        qeps_pkg::exp_word_t          exp_reg;
        logic [qeps_pkg::PROD_W-1:0]  prod;
        logic [qeps_pkg::PROD_W-1:0]  shifted;
        logic [qeps_pkg::SHIFT_W-1:0] shift_amt;
        logic [PHASE_BITS-1:0]        inc_reg;

        qeps_pitch_exp #(
            .EXP_ADDR_BITS (EXP_ADDR_BITS)
        ) u_pitch_exp (
            .knob (knob_reg[c]),
            .cv   (cv_reg[c]),
            .word (exp_word)
        );

        always_ff @(posedge clk)
        begin
            if (s2_free && s1_valid_reg) begin
                exp_reg <= exp_word;
            end
        end

        // Increment = (base_step * mantissa) >> (30 - octave), octave -4..4.
        assign prod      = qeps_pkg::PROD_W'(base_step_reg) * qeps_pkg::PROD_W'(exp_reg.mant);
        assign shift_amt = qeps_pkg::SHIFT_TOP - qeps_pkg::SHIFT_W'(exp_reg.code);
        assign shifted   = prod >> shift_amt;

        always_ff @(posedge clk)
        begin
            if (s3_free && s2_valid_reg) begin
                inc_reg <= shifted[PHASE_BITS-1:0];
            end
        end

        assign phase_next[c] = phase_acc_reg[c] + inc_reg;

        qeps_sine_lookup #(
            .SINE_ADDR_BITS (SINE_ADDR_BITS)
        ) u_sine (
            .addr   (phase_next[c][PHASE_BITS-1 -: SINE_ADDR_BITS]),
            .sample (sample[c])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                phase_acc_reg[c] <= '0;
            end else if (s4_free && s3_valid_reg) begin
                phase_acc_reg[c] <= phase_next[c];
            end
        end

        always_ff @(posedge clk)
        begin
            if (s4_free && s3_valid_reg) begin
                wave_reg[c] <= sample[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register drives the wave channel directly.
    // ------------------------------------------------------------------
    assign wave.valid  = s4_valid_reg;
    assign wave.wave_a = wave_reg[0];
    assign wave.wave_b = wave_reg[1];
    assign wave.wave_c = wave_reg[2];
    assign wave.wave_d = wave_reg[3];

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench for the four-channel sine oscillator core
// A directed table walks register writes and pitch transfers with the easy
// results typed in. Random phases follow under changing idle and stall
// patterns. Every wave transfer is checked field by field against an
// in-bench model of the pitch, exponent, accumulate and sine path.
// ============================================================================
module tb_top;

    // Core configuration as instantiated (defaults of the core).
    localparam int PHASE_W     = 32;
    localparam int SINE_AW     = 10;
    localparam int EXP_AW      = 8;
    localparam int QUARTER     = 1 << (SINE_AW - 2);
    localparam int PITCH_LIMIT = 16384;  // +4 V in Q4.12

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int PIPE_SETTLE     = 8;
    localparam int CYCLE_LIMIT     = 300000;

    // Register indexes the core has no register behind.
    localparam logic [qeps_pkg::CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [qeps_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [qeps_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    // Channel 0 is channel a.
    typedef logic [qeps_pkg::CHANNELS-1:0][qeps_pkg::CV_W-1:0]   cv_vec_t;
    typedef logic [qeps_pkg::CHANNELS-1:0][qeps_pkg::WAVE_W-1:0] wave_vec_t;

    typedef enum logic {ROW_CFG, ROW_PITCH} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    // One row of the directed table: either a register write or a pitch
    // transfer, optionally with its result typed in.
    typedef struct packed {
        row_kind_t                       kind;
        logic [qeps_pkg::CFG_IDX_W-1:0]  idx;
        logic [qeps_pkg::CFG_DATA_W-1:0] data;
        cv_vec_t                         cv;
        logic                            has_want;
        wave_vec_t                       want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    qeps_cv_if   cv_bus ();
    qeps_wave_if wave_bus ();
    qeps_cfg_if  cfg_bus ();

    quad_exp_pitch_sine_oscillator_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cv    (cv_bus),
        .wave  (wave_bus),
        .cfg   (cfg_bus)
    );

    // Lookup tables of the bench model: the Q30 mantissa 2^(e/256) and the
    // rounded quarter-wave sine, both rebuilt here from first principles.
    logic [63:0] exp_mant_tbl [1 << EXP_AW];
    logic [63:0] qsine_tbl [QUARTER + 1];

    // Register and accumulator copies of the bench model.
    logic [qeps_pkg::BASE_W-1:0] base_reg;
    logic [qeps_pkg::KNOB_W-1:0] knob_reg [qeps_pkg::CHANNELS];
    logic [PHASE_W-1:0]          phase_reg [qeps_pkg::CHANNELS];

    // Wave samples still owed by the core, oldest first.
    wave_vec_t wave_expect_q [$];

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int pitch_sent     = 0;
    int waves_checked  = 0;
    int reg_writes     = 0;
    int cycle_count    = 0;

    wave_vec_t wave_seen;
    wave_vec_t wave_due;

    // Build both tables at time zero, long before reset is released.
    initial
    begin
        logic [63:0] roots [EXP_AW + 1];
        logic [63:0] radicand;
        logic [63:0] guess;
        logic [63:0] trial;
        logic [63:0] acc;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;

        // Repeated square roots of two in Q30; each one is the floor of the
        // exact root, found bit by bit from the top.
        roots[0] = 64'd1 << 31;
        for (int j = 1; j <= EXP_AW; j++)
        begin
            radicand = roots[j-1] << 30;
            guess    = 64'd0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = guess | (64'd1 << b);
                if (trial * trial <= radicand)
                    guess = trial;
            end
            roots[j] = guess;
        end

        // Each mantissa is the rounded product of the roots whose weight
        // bit is set in the address, most significant weight first.
        for (int e = 0; e < (1 << EXP_AW); e++)
        begin
            acc = 64'd1 << 30;
            for (int j = 1; j <= EXP_AW; j++)
                if (((e >> (EXP_AW - j)) & 1) != 0)
                    acc = (acc * roots[j] + (64'd1 << 29)) >> 30;
            exp_mant_tbl[e] = acc;
        end

        // Nine-term Taylor sine in Q30 with every term truncated, then
        // scaled to 32767 and rounded half up.
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = (qeps_pkg::HALF_PI_Q30 * 64'(k)) >> (SINE_AW - 2);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n % 2) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            qsine_tbl[k] = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        end
    end

    // Advance all four accumulators for one accepted pitch transfer and
    // return the samples the core must produce for it.
    task automatic advance_phases(input cv_vec_t pitch_cv, output wave_vec_t samples);
        int          pitch;
        int          biased;
        int          octave;
        logic [63:0] mant;
        logic [63:0] inc;
        logic [9:0]  addr;
        logic [8:0]  k;
        logic [63:0] mag;

        for (int c = 0; c < qeps_pkg::CHANNELS; c++)
        begin
            // Knob plus CV, saturated to plus or minus 4 V.
            pitch = int'($signed(knob_reg[c])) + int'($signed(pitch_cv[c]));
            if (pitch > PITCH_LIMIT)
                pitch = PITCH_LIMIT;
            if (pitch < -PITCH_LIMIT)
                pitch = -PITCH_LIMIT;

            // Octave -4..4 from the integer part, mantissa from the top
            // fraction bits; the increment is base * 2^pitch, truncated.
            biased = pitch + PITCH_LIMIT;
            octave = (biased >> 12) - 4;
            mant   = exp_mant_tbl[(biased & 4095) >> (12 - EXP_AW)];
            inc    = (64'(base_reg) * mant) >> (30 - octave);

            phase_reg[c] = phase_reg[c] + inc[PHASE_W-1:0];

            // Quarter-wave lookup: odd quarters mirror, upper half negates.
            addr = phase_reg[c][PHASE_W-1 -: SINE_AW];
            k    = addr[SINE_AW-2] ? (9'(QUARTER) - 9'(addr[SINE_AW-3:0]))
                                   : 9'(addr[SINE_AW-3:0]);
            mag  = qsine_tbl[k];
            samples[c] = addr[SINE_AW-1] ? qeps_pkg::WAVE_W'(-mag)
                                         : mag[qeps_pkg::WAVE_W-1:0];
        end
    endtask

    // Register write on the config channel. Valid stays high on return so
    // that back-to-back writes need no extra edge.
    task automatic reg_write(input logic [qeps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qeps_pkg::CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        if (idx == qeps_pkg::REG_BASE_STEP)
            base_reg = data[qeps_pkg::BASE_W-1:0];
        else if (idx >= qeps_pkg::REG_KNOB_A && idx <= qeps_pkg::REG_KNOB_D)
            knob_reg[idx - qeps_pkg::REG_KNOB_A] = data[qeps_pkg::KNOB_W-1:0];
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic cfg_release();
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // One pitch transfer, preceded by random sender gaps. The expectation
    // is either the typed-in value or the bench model's prediction.
    task automatic pitch_send(input cv_vec_t pitch_cv, input logic has_want,
                              input wave_vec_t want);
        wave_vec_t predicted;

        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            cv_bus.valid <= 1'b0;
            @(negedge clk);
        end
        cv_bus.valid      <= 1'b1;
        cv_bus.cv_pitch_a <= pitch_cv[0];
        cv_bus.cv_pitch_b <= pitch_cv[1];
        cv_bus.cv_pitch_c <= pitch_cv[2];
        cv_bus.cv_pitch_d <= pitch_cv[3];
        @(posedge clk);
        while (cv_bus.ready !== 1'b1)
            @(posedge clk);
        advance_phases(pitch_cv, predicted);
        wave_expect_q.push_back(has_want ? want : predicted);
        pitch_sent++;
        @(negedge clk);
    endtask

    task automatic pitch_release();
        cv_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every owed sample has arrived, then let the pipeline run
    // dry before registers are touched.
    task automatic pipeline_drain();
        while (wave_expect_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    function automatic logic [qeps_pkg::CFG_DATA_W-1:0] knob_data(input int volts_q412);
        return volts_q412[qeps_pkg::CFG_DATA_W-1:0];
    endfunction

    function automatic stim_row_t cfg_row(input logic [qeps_pkg::CFG_IDX_W-1:0] idx,
                                          input int value);
        stim_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = value[qeps_pkg::CFG_DATA_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t pitch_row(input int a, input int b, input int c, input int d,
                                            input logic has_want, input int want_all);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_PITCH;
        r.cv[0]    = a[qeps_pkg::CV_W-1:0];
        r.cv[1]    = b[qeps_pkg::CV_W-1:0];
        r.cv[2]    = c[qeps_pkg::CV_W-1:0];
        r.cv[3]    = d[qeps_pkg::CV_W-1:0];
        r.has_want = has_want;
        for (int ch = 0; ch < qeps_pkg::CHANNELS; ch++)
            r.want[ch] = want_all[qeps_pkg::WAVE_W-1:0];
        return r;
    endfunction

    // Random pitch voltages: mostly inside the clamp window so the whole
    // exponent table is swept, plus full-scale values, extremes and small
    // values around zero.
    function automatic cv_vec_t random_cv();
        cv_vec_t v;
        int      val;

        for (int c = 0; c < qeps_pkg::CHANNELS; c++)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: val = int'($urandom_range(0, 40959)) - 20480;
                4, 5:       val = int'($urandom_range(0, 81919)) - 40960;
                6:
                begin
                    case ($urandom_range(0, 4))
                        0:       val = -40960;
                        1:       val = 40959;
                        2:       val = -PITCH_LIMIT;
                        3:       val = PITCH_LIMIT;
                        default: val = 0;
                    endcase
                end
                default:    val = int'($urandom_range(0, 8191)) - 4096;
            endcase
            v[c] = val[qeps_pkg::CV_W-1:0];
        end
        return v;
    endfunction

    function automatic int random_knob();
        case ($urandom_range(0, 9))
            0:       return 12288;
            1:       return -12288;
            2:       return int'($urandom_range(0, 32767)) - 16384;  // beyond 3 V
            default: return int'($urandom_range(0, 24576)) - 12288;
        endcase
    endfunction

    function automatic logic [qeps_pkg::CFG_DATA_W-1:0] random_base();
        case ($urandom_range(0, 7))
            0:       return 28'hFFFFFFF;
            1:       return qeps_pkg::BASE_STEP_RESET;
            2, 3:    return qeps_pkg::CFG_DATA_W'($urandom());
            default: return qeps_pkg::CFG_DATA_W'($urandom() >> $urandom_range(4, 22));
        endcase
    endfunction

    // Wave-side back pressure, redrawn every cycle from the current stall
    // percentage. It is the only driver of ready.
    initial
    begin
        wave_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            wave_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Result checker: each wave transfer is matched against the oldest
    // expectation, channel by channel.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && wave_bus.valid === 1'b1 && wave_bus.ready === 1'b1)
        begin
            wave_seen[0] = wave_bus.wave_a;
            wave_seen[1] = wave_bus.wave_b;
            wave_seen[2] = wave_bus.wave_c;
            wave_seen[3] = wave_bus.wave_d;
            if (wave_expect_q.size() == 0)
            begin
                $display("%0t: wave transfer with nothing pending, got %h", $time, wave_seen);
                mismatches++;
            end
            else
            begin
                wave_due = wave_expect_q.pop_front();
                waves_checked++;
                for (int c = 0; c < qeps_pkg::CHANNELS; c++)
                begin
                    if (wave_seen[c] !== wave_due[c])
                    begin
                        $display("%0t: wave_%c mismatch, expected %0d, got %0d", $time,
                                 8'd97 + c, $signed(wave_due[c]), $signed(wave_seen[c]));
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t  directed_tbl [$];
        stim_row_t  row;
        bit         cv_open;
        bit         cfg_open;
        idle_mode_t mode;

        // Every input known from time zero; reset is held low before release.
        rst_n             = 1'b0;
        cv_bus.valid      = 1'b0;
        cv_bus.cv_pitch_a = '0;
        cv_bus.cv_pitch_b = '0;
        cv_bus.cv_pitch_c = '0;
        cv_bus.cv_pitch_d = '0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = qeps_pkg::REG_BASE_STEP;
        cfg_bus.data      = '0;
        cv_open           = 1'b0;
        cfg_open          = 1'b0;

        base_reg = qeps_pkg::BASE_STEP_RESET;
        for (int c = 0; c < qeps_pkg::CHANNELS; c++)
        begin
            knob_reg[c]  = '0;
            phase_reg[c] = '0;
        end

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table. With a zero base step the accumulators never leave
        // zero, whatever the CV, so the extremes of the CV give zero samples.
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_BASE_STEP, 0));
        directed_tbl.push_back(pitch_row(-40960, 40959, 0, -1, 1'b1, 0));
        directed_tbl.push_back(pitch_row(40959, -40960, PITCH_LIMIT, -PITCH_LIMIT, 1'b1, 0));
        // Base step 2^26 at +4 V steps each accumulator by a quarter turn, so
        // the samples walk through the peaks and zero crossings and wrap.
        // The writes to unused indexes must leave that setting untouched.
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_BASE_STEP, 1 << 26));
        directed_tbl.push_back(cfg_row(REG_SPARE_5, 0));
        directed_tbl.push_back(cfg_row(REG_SPARE_6, 0));
        directed_tbl.push_back(cfg_row(REG_SPARE_7, 0));
        directed_tbl.push_back(pitch_row(PITCH_LIMIT, 40959, 20000, PITCH_LIMIT, 1'b1, 32767));
        directed_tbl.push_back(pitch_row(PITCH_LIMIT, 40959, 20000, PITCH_LIMIT, 1'b1, 0));
        directed_tbl.push_back(pitch_row(PITCH_LIMIT, 40959, 20000, PITCH_LIMIT, 1'b1, -32767));
        directed_tbl.push_back(pitch_row(PITCH_LIMIT, 40959, 20000, PITCH_LIMIT, 1'b1, 0));
        // Knob extremes, and knob values past 3 V that are used as written.
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_KNOB_A, 12288));
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_KNOB_B, -12288));
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_KNOB_C, 16383));
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_KNOB_D, -16384));
        directed_tbl.push_back(pitch_row(4096, 28672, 1, 40959, 1'b1, 32767));
        directed_tbl.push_back(pitch_row(4096, 40959, 1, 40959, 1'b1, 0));
        directed_tbl.push_back(pitch_row(10000, 30000, 20000, 40000, 1'b1, -32767));
        directed_tbl.push_back(pitch_row(10000, 30000, 20000, 40000, 1'b1, 0));
        // From here the model predicts: low clamp, zero CV, mixed values,
        // and the largest base step.
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_BASE_STEP,
                                       int'(qeps_pkg::BASE_STEP_RESET)));
        directed_tbl.push_back(pitch_row(-40960, -40960, -40960, -40960, 1'b0, 0));
        directed_tbl.push_back(pitch_row(0, 0, 0, 0, 1'b0, 0));
        directed_tbl.push_back(pitch_row(-28672, 12288, -16383, PITCH_LIMIT, 1'b0, 0));
        directed_tbl.push_back(cfg_row(qeps_pkg::REG_BASE_STEP, 28'hFFFFFFF));
        directed_tbl.push_back(pitch_row(40959, 40959, 40959, 40959, 1'b0, 0));
        directed_tbl.push_back(pitch_row(-4095, 2047, -20481, 8191, 1'b0, 0));

        // Register rows only go in once all earlier pitch transfers are out.
        foreach (directed_tbl[i])
        begin
            row = directed_tbl[i];
            if (row.kind == ROW_CFG)
            begin
                if (cv_open)
                begin
                    pitch_release();
                    pipeline_drain();
                    cv_open = 1'b0;
                end
                reg_write(row.idx, row.data);
                cfg_open = 1'b1;
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_release();
                    cfg_open = 1'b0;
                end
                pitch_send(row.cv, row.has_want, row.want);
                cv_open = 1'b1;
            end
        end
        if (cfg_open)
            cfg_release();
        if (cv_open)
            pitch_release();

        // Random phases, each with fresh register settings and an idle
        // pattern of its own: none, sender gaps, receiver stalls, both.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            pipeline_drain();
            if (ph == 0)
            begin
                reg_write(qeps_pkg::REG_BASE_STEP, 28'hFFFFFFF);
                reg_write(qeps_pkg::REG_KNOB_A, knob_data(12288));
                reg_write(qeps_pkg::REG_KNOB_B, knob_data(-12288));
                reg_write(qeps_pkg::REG_KNOB_C, knob_data(16383));
                reg_write(qeps_pkg::REG_KNOB_D, knob_data(-16384));
            end
            else if (ph == PHASES - 1)
            begin
                // Back to the reset values.
                reg_write(qeps_pkg::REG_BASE_STEP, qeps_pkg::BASE_STEP_RESET);
                reg_write(qeps_pkg::REG_KNOB_A, knob_data(0));
                reg_write(qeps_pkg::REG_KNOB_B, knob_data(0));
                reg_write(qeps_pkg::REG_KNOB_C, knob_data(0));
                reg_write(qeps_pkg::REG_KNOB_D, knob_data(0));
            end
            else
            begin
                reg_write(qeps_pkg::REG_BASE_STEP, random_base());
                reg_write(qeps_pkg::REG_KNOB_A, knob_data(random_knob()));
                reg_write(qeps_pkg::REG_KNOB_B, knob_data(random_knob()));
                reg_write(qeps_pkg::REG_KNOB_C, knob_data(random_knob()));
                reg_write(qeps_pkg::REG_KNOB_D, knob_data(random_knob()));
            end
            // A stray write to an unused index must change nothing.
            reg_write(qeps_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_5, REG_SPARE_7)),
                      qeps_pkg::CFG_DATA_W'($urandom()));
            cfg_release();

            mode           = idle_mode_t'(ph % 4);
            src_gap_pct    = (mode == IDLE_SRC) ? 64 : (mode == IDLE_BOTH) ? 18 : 0;
            sink_stall_pct = (mode == IDLE_SINK) ? 64 : (mode == IDLE_BOTH) ? 18 : 0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Now and then the sender holds off until the core has
                // handed back every sample it owes.
                if (n == ITEMS_PER_PHASE / 2 && (ph % 3) == 1)
                begin
                    pitch_release();
                    while (wave_expect_q.size() != 0)
                        @(negedge clk);
                end
                pitch_send(random_cv(), 1'b0, '0);
            end
            pitch_release();
        end

        pipeline_drain();

        $display("Covered %0d pitch transfers (directed table and %0d idle-pattern phases),",
                 pitch_sent, PHASES);
        $display("%0d register writes, %0d wave transfers compared, %0d field mismatches.",
                 reg_writes, waves_checked, mismatches);
        if (mismatches == 0 && wave_expect_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
